[hdl/button_gesture_classifier_top_defines.svh]
// Assertion macros for the verification of the gesture classifier, used by bgc_checker.
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define BGC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the following cycle.
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bgc_pkg.sv]
`timescale 1ns / 1ps

package bgc_pkg;

    // Sizes of the stream payloads and the configuration port.
    localparam int BGC_MAX_BUTTONS = 16;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 8;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;

    // Field widths.
    localparam int INDEX_W  = 4;
    localparam int TIME_W   = 32;
    localparam int STATE_W  = 3;
    localparam int LONG_W   = 15;
    localparam int DOUBLE_W = 16;
    localparam int COUNT_W  = 5;

    // Register values after reset.
    localparam logic [LONG_W-1:0]   LONG_PRESS_RESET   = 15'd1000;
    localparam logic [DOUBLE_W-1:0] DOUBLE_PRESS_RESET = 16'd300;
    localparam logic [COUNT_W-1:0]  BUTTON_COUNT_RESET = 5'd16;

    // Gesture codes as they appear on the result stream.
    typedef enum logic [STATE_W-1:0] {
        GS_REST       = 3'd0,
        GS_PRESSED    = 3'd1,
        GS_STILL      = 3'd2,
        GS_LONG       = 3'd3,
        GS_STILL_LONG = 3'd4,
        GS_DOUBLE     = 3'd5,
        GS_RELEASED   = 3'd6
    } gesture_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LONG_PRESS   = 2'd0,
        CFG_DOUBLE_PRESS = 2'd1,
        CFG_BUTTON_COUNT = 2'd2
    } cfg_index_t;

    // Controller states.
    typedef enum logic [1:0] {
        CTL_IDLE   = 2'd0,
        CTL_UPDATE = 2'd1,
        CTL_RESULT = 2'd2
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic load;
    } bgc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } bgc_status_t;

endpackage

[hdl/bgc_ctrl.sv]
`timescale 1ns / 1ps

module bgc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bgc_pkg::bgc_status_t status,
    output bgc_pkg::bgc_cmd_t    cmd
);
    import bgc_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing of one request: capture and read, update, then hand over the result.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = CTL_UPDATE;
                end
            end
            CTL_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = CTL_RESULT;
            end
            CTL_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

[hdl/bgc_datapath.sv]
`timescale 1ns / 1ps

module bgc_datapath
#(
    parameter int MAX_BUTTONS = bgc_pkg::BGC_MAX_BUTTONS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bgc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bgc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_wen,
    input  logic [bgc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  bgc_pkg::bgc_cmd_t                 cmd,
    output bgc_pkg::bgc_status_t              status
);
    import bgc_pkg::*;

    localparam int ADDR_W  = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam int ENTRY_W = STATE_W + TIME_W;

    // Configuration registers.
    logic [LONG_W-1:0]   long_press_reg;
    logic [DOUBLE_W-1:0] double_press_reg;
    logic [COUNT_W-1:0]  button_count_reg;

    // Per-button store: state and action time, with a written bit per entry.
    logic [ENTRY_W-1:0]     entry_mem [MAX_BUTTONS];
    logic [MAX_BUTTONS-1:0] written_reg;
    logic [MAX_BUTTONS-1:0] busy_reg;

    // Captured request and read data.
    logic [ADDR_W-1:0]  addr_reg;
    logic               level_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               in_range_reg;
    logic [ENTRY_W-1:0] rd_entry_reg;
    logic               rd_valid_reg;
    logic [STATE_W-1:0] result_state_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // Request fields.
    logic [INDEX_W-1:0] in_index;
    logic [ADDR_W-1:0]  in_addr;
    logic               in_range;

    // Update logic.
    logic [STATE_W-1:0] cur_state;
    logic [TIME_W-1:0]  cur_time;
    logic [TIME_W-1:0]  delta;
    gesture_t           state_next;
    logic [TIME_W-1:0]  time_next;

    // Search for the lowest button not at rest.
    logic [MAX_BUTTONS-1:0] use_mask;
    logic [MAX_BUTTONS-1:0] live;
    logic [MAX_BUTTONS-1:0] lowest;
    logic [ADDR_W-1:0]      where;
    logic                   found;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_addr  = ADDR_W'(in_index);
    assign in_range = (int'(in_index) < int'(button_count_reg))
                   && (int'(in_index) < MAX_BUTTONS);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= LONG_PRESS_RESET;
            double_press_reg <= DOUBLE_PRESS_RESET;
            button_count_reg <= BUTTON_COUNT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_LONG_PRESS:   long_press_reg   <= cfg_wdata[LONG_W-1:0];
                CFG_DOUBLE_PRESS: double_press_reg <= cfg_wdata[DOUBLE_W-1:0];
                CFG_BUTTON_COUNT: button_count_reg <= cfg_wdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Capture the request and read the button's entry.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg     <= in_addr;
            level_reg    <= s_tdata[INDEX_W];
            now_reg      <= s_tdata[INDEX_W+TIME_W:INDEX_W+1];
            in_range_reg <= in_range;
            rd_entry_reg <= entry_mem[in_addr];
            rd_valid_reg <= written_reg[in_addr];
        end
    end

    // An entry never written reads as rest at time zero.
    assign cur_state = rd_valid_reg ? rd_entry_reg[ENTRY_W-1:TIME_W] : STATE_W'(GS_REST);
    assign cur_time  = rd_valid_reg ? rd_entry_reg[TIME_W-1:0] : '0;
    assign delta     = now_reg - cur_time;

    // Gesture transition for the captured sample.
    always_comb
    begin
        state_next = gesture_t'(cur_state);
        time_next  = cur_time;
        if (level_reg)
        begin
            case (gesture_t'(cur_state))
                GS_PRESSED:    state_next = GS_STILL;
                GS_LONG:       state_next = GS_STILL_LONG;
                GS_STILL:
                begin
                    if (delta > TIME_W'(long_press_reg))
                    begin
                        state_next = GS_LONG;
                    end
                end
                GS_STILL_LONG: state_next = GS_STILL_LONG;
                GS_DOUBLE:     state_next = GS_DOUBLE;
                default:
                begin
                    // Rest, released and the unused code start a new press.
                    if (delta < TIME_W'(double_press_reg))
                    begin
                        state_next = GS_DOUBLE;
                    end
                    else
                    begin
                        state_next = GS_PRESSED;
                        time_next  = now_reg;
                    end
                end
            endcase
        end
        else
        begin
            case (gesture_t'(cur_state))
                GS_PRESSED, GS_STILL, GS_LONG, GS_STILL_LONG:
                begin
                    state_next = GS_RELEASED;
                    time_next  = now_reg;
                end
                default:
                begin
                    state_next = GS_REST;
                end
            endcase
        end
    end

    // Write back the entry of a button in use.
    always_ff @(posedge clk)
    begin
        if (cmd.update && in_range_reg)
        begin
            entry_mem[addr_reg] <= {STATE_W'(state_next), time_next};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            result_state_reg <= in_range_reg ? STATE_W'(state_next) : STATE_W'(GS_REST);
        end
    end

    // Written and not-at-rest bits, one per button.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            busy_reg    <= '0;
        end
        else if (cmd.update && in_range_reg)
        begin
            written_reg[addr_reg] <= 1'b1;
            busy_reg[addr_reg]    <= (state_next != GS_REST);
        end
    end

    // Lowest button in use that is not at rest: isolate the lowest set bit, then encode it.
    always_comb
    begin
        for (int i = 0; i < MAX_BUTTONS; i++)
        begin
            use_mask[i] = (i < int'(button_count_reg));
        end
        live   = busy_reg & use_mask;
        lowest = live & (~live + MAX_BUTTONS'(1));
        found  = |live;
        where  = '0;
        for (int i = 0; i < MAX_BUTTONS; i++)
        begin
            if (lowest[i])
            begin
                where = where | ADDR_W'(i);
            end
        end
    end

    // Output register: holds a result until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= {INDEX_W'(where), found, result_state_reg};
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule

[hdl/button_gesture_classifier_top.sv]
`timescale 1ns / 1ps

// Button gesture classifier. Each request carries one sampled button level with
// its button index and a wrapping millisecond timestamp; the block steps that
// button's gesture state (rest, pressed, still, long, still long, double,
// released) and returns one result per request: the button's new state and the
// lowest-numbered button in use that is not at rest. A request is handled in
// order: the first step accepts it and reads its entry from the per-button store,
// the second computes the transition and writes the entry back, and the last
// searches the not-at-rest bits and loads the output register once it is free.
// The read of the store is registered. A result waiting in the output register
// does not stop the next request from being accepted once it is loaded; a
// further result waits until the pending one is taken. Reset clears the store
// at once through one written bit per entry, so no clearing pass is needed.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this.
module button_gesture_classifier_top
#(
    parameter int MAX_BUTTONS = bgc_pkg::BGC_MAX_BUTTONS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: button_index[3:0], level[4], now_ms[36:5], zero fill[39:37]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bgc_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: new_state[2:0], active_found[3], active_index[7:4]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bgc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_wen,
    input  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bgc_pkg::*;

    bgc_cmd_t    cmd;
    bgc_status_t status;

    // Sequencer.
    bgc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, transition logic, search and output register.
    bgc_datapath
    #(
        .MAX_BUTTONS (MAX_BUTTONS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[hdl/bgc_checker.sv]
`timescale 1ns / 1ps

`include "button_gesture_classifier_top_defines.svh"

module bgc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bgc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import bgc_pkg::*;

    // A stalled result keeps its value.
    `BGC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // One request at a time: no request is taken in the cycle after one is accepted.
    `BGC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // With no button active, the reported index is zero.
    `BGC_ASSERT_SAME(a_idle_index, m_tvalid && !m_tdata[3], m_tdata[7:4] == 4'd0, "index set with none active")

    // The unused gesture code never appears.
    `BGC_ASSERT_SAME(a_state_code, m_tvalid, m_tdata[2:0] != 3'd7, "invalid gesture code")

endmodule

bind button_gesture_classifier_top bgc_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bgc_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PER_PHASE  = 100;
    localparam int N_PHASES   = 13;
    localparam int N_ROWS     = 28;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

    // One result with the fields carried on m_tdata, packed in reverse field order.
    typedef struct packed {
        gesture_t           state;
        logic               found;
        logic [INDEX_W-1:0] where_idx;
    } gesture_result_t;

    // One line of the directed sequence: a register write or a request.
    typedef struct packed {
        row_kind_t             kind;
        cfg_index_t            cfg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic [INDEX_W-1:0]    button;
        logic                  level;
        logic [TIME_W-1:0]     now_ms;
        logic                  typed;
        gesture_result_t       res;
    } press_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Shadow copy of the per-button store and the registers.
    gesture_t            shadow_state [BGC_MAX_BUTTONS];
    logic [TIME_W-1:0]   action_stamp [BGC_MAX_BUTTONS];
    logic                last_level   [BGC_MAX_BUTTONS];
    logic [LONG_W-1:0]   long_ms;
    logic [DOUBLE_W-1:0] double_ms;
    logic [COUNT_W-1:0]  count_reg;

    gesture_result_t gesture_q [$];
    gesture_result_t oldest;
    press_row_t      dir_rows [N_ROWS];

    int        errors          = 0;
    int        samples_sent    = 0;
    int        results_checked = 0;
    int        settings_used   = 0;
    int        idle_cycles     = 0;
    int        burst_left      = 0;
    int        max_gap         = 0;
    int        state_tally [8];
    logic [15:0] rx_cycle      = '0;

    button_gesture_classifier_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Buttons in use: the count register saturates at the store depth.
    function automatic int buttons_used();
        return (count_reg > BGC_MAX_BUTTONS) ? BGC_MAX_BUTTONS : int'(count_reg);
    endfunction

    // Steps one button's gesture state and finds the lowest button not at rest.
    function automatic gesture_result_t classify(input logic [INDEX_W-1:0] b,
                                                 input logic lv,
                                                 input logic [TIME_W-1:0] t);
        gesture_result_t   r;
        gesture_t          s;
        logic [TIME_W-1:0] dt;
        int                used;
        int                i;
        used        = buttons_used();
        r.state     = GS_REST;
        r.found     = 1'b0;
        r.where_idx = '0;
        if (b < used)
        begin
            s  = shadow_state[b];
            dt = t - action_stamp[b];
            if (lv)
            begin
                case (s)
                    GS_REST, GS_RELEASED:
                    begin
                        if (dt < double_ms)
                            s = GS_DOUBLE;
                        else
                        begin
                            s = GS_PRESSED;
                            action_stamp[b] = t;
                        end
                    end
                    GS_LONG:    s = GS_STILL_LONG;
                    GS_PRESSED: s = GS_STILL;
                    GS_STILL:   if (dt > long_ms) s = GS_LONG;
                    default:    ;
                endcase
            end
            else
            begin
                case (s)
                    GS_PRESSED, GS_STILL, GS_LONG, GS_STILL_LONG:
                    begin
                        s = GS_RELEASED;
                        action_stamp[b] = t;
                    end
                    default: s = GS_REST;
                endcase
            end
            shadow_state[b] = s;
            r.state = s;
        end
        for (i = used - 1; i >= 0; i--)
        begin
            if (shadow_state[i] != GS_REST)
            begin
                r.found     = 1'b1;
                r.where_idx = i[INDEX_W-1:0];
            end
        end
        return r;
    endfunction

    // Presents one request in the current burst and waits for it to be taken.
    task automatic push_sample(input logic [INDEX_W-1:0] b, input logic lv,
                               input logic [TIME_W-1:0] t, input logic typed,
                               input gesture_result_t typed_res);
        int              gap;
        gesture_result_t pred;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (max_gap > 0)
            begin
                gap = $urandom_range(1, max_gap);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t, lv, b};
        do
            @(posedge clk);
        while (!s_tready);
        pred = classify(b, lv, t);
        gesture_q.push_back(typed ? typed_res : pred);
        samples_sent++;
    endtask

    // Stops sending and waits until every result has been taken.
    task automatic settle_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (gesture_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Drives one register write and records it in the shadow registers.
    task automatic write_reg(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        case (sel)
            CFG_LONG_PRESS:   long_ms   = val[LONG_W-1:0];
            CFG_DOUBLE_PRESS: double_ms = val[DOUBLE_W-1:0];
            CFG_BUTTON_COUNT: count_reg = val[COUNT_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
    endtask

    // Receiver stall pattern, changing character as its cycle counter advances.
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (rx_cycle % 5) != 0;
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (gesture_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                oldest = gesture_q.pop_front();
                results_checked++;
                state_tally[m_tdata[2:0]]++;
                if (m_tdata[2:0] !== oldest.state)
                begin
                    $display("%0t: new_state expected %0d actual %0d",
                             $time, oldest.state, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[3] !== oldest.found)
                begin
                    $display("%0t: active_found expected %0d actual %0d",
                             $time, oldest.found, m_tdata[3]);
                    errors++;
                end
                if (m_tdata[7:4] !== oldest.where_idx)
                begin
                    $display("%0t: active_index expected %0d actual %0d",
                             $time, oldest.where_idx, m_tdata[7:4]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which no request and no result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, gesture_q.size());
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                  phase;
        int                  counted;
        int                  used;
        int                  i;
        logic [INDEX_W-1:0]  b;
        logic                lv;
        logic [TIME_W-1:0]   t;
        logic [TIME_W-1:0]   base;
        logic [LONG_W-1:0]   lng;
        logic [DOUBLE_W-1:0] dbl;
        logic [COUNT_W-1:0]  cnt;

        long_ms   = LONG_PRESS_RESET;
        double_ms = DOUBLE_PRESS_RESET;
        count_reg = BUTTON_COUNT_RESET;
        for (i = 0; i < BGC_MAX_BUTTONS; i++)
        begin
            shadow_state[i] = GS_REST;
            action_stamp[i] = '0;
            last_level[i]   = 1'b0;
        end
        for (i = 0; i < 8; i++)
            state_tally[i] = 0;

        // Directed sequence, starting from the reset register values.
        dir_rows = '{
            // First press after reset lands within the double window of time zero.
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd0,  1'b1, 32'd0, 1'b1,
              '{GS_DOUBLE, 1'b1, 4'd0}},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd0,  1'b1, 32'd5, 1'b1,
              '{GS_DOUBLE, 1'b1, 4'd0}},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd0,  1'b0, 32'd10, 1'b1,
              '{GS_REST, 1'b0, 4'd0}},
            // Top button through still, the long press edge and still long.
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b1, 32'd1000, 1'b1,
              '{GS_PRESSED, 1'b1, 4'd15}},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b1, 32'd1001, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b1, 32'd2000, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b1, 32'd2001, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b1, 32'd2002, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b0, 32'd2004, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b1, 32'd2100, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b0, 32'd2101, 1'b0, '0},
            // Timestamps that wrap through zero between press and long press.
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd3,  1'b1, 32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd3,  1'b1, 32'd5, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd3,  1'b1, 32'd1000, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd3,  1'b0, 32'd2000, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd3,  1'b1, 32'd2299, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd3,  1'b0, 32'd2300, 1'b0, '0},
            // Press exactly at the double window edge, then release to rest.
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd1,  1'b1, 32'd10000, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd1,  1'b0, 32'd10001, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd1,  1'b1, 32'd10301, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd1,  1'b0, 32'd10302, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd1,  1'b0, 32'd10303, 1'b0, '0},
            // An index beyond the buttons in use changes nothing.
            '{ROW_WRITE,  CFG_BUTTON_COUNT, 16'd2, 4'd0, 1'b0, 32'd0, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd5,  1'b1, 32'd777, 1'b1,
              '{GS_REST, 1'b0, 4'd0}},
            // With no buttons in use every request is ignored.
            '{ROW_WRITE,  CFG_BUTTON_COUNT, 16'd0, 4'd0, 1'b0, 32'd0, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd0,  1'b1, 32'd12345, 1'b1,
              '{GS_REST, 1'b0, 4'd0}},
            // A count above the store depth saturates.
            '{ROW_WRITE,  CFG_BUTTON_COUNT, 16'd31, 4'd0, 1'b0, 32'd0, 1'b0, '0},
            '{ROW_SAMPLE, CFG_LONG_PRESS, 16'd0, 4'd15, 1'b1, 32'd50000, 1'b0, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        max_gap = 3;
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_WRITE)
            begin
                settle_idle();
                write_reg(dir_rows[r].cfg_sel, dir_rows[r].value);
                cfg_wen <= 1'b0;
                settings_used++;
            end
            else
                push_sample(dir_rows[r].button, dir_rows[r].level, dir_rows[r].now_ms,
                            dir_rows[r].typed, dir_rows[r].res);
        end

        // Random phases, each with its own register setting and sender pacing.
        b = '0;
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            settle_idle();
            case (phase)
                0: begin lng = 15'd1000;  dbl = 16'd300;   cnt = 5'd16; max_gap = 4; end
                1: begin lng = 15'd0;     dbl = 16'd0;     cnt = 5'd16; max_gap = 0; end
                2: begin lng = 15'd32767; dbl = 16'd65535; cnt = 5'd16; max_gap = 8; end
                3: begin lng = 15'd50;    dbl = 16'd20;    cnt = 5'd4;  max_gap = 3; end
                4: begin lng = 15'd32767; dbl = 16'd0;     cnt = 5'd1;  max_gap = 0; end
                5: begin lng = 15'd0;     dbl = 16'd65535; cnt = 5'd16; max_gap = 6; end
                6: begin lng = 15'd200;   dbl = 16'd100;   cnt = 5'd31; max_gap = 2; end
                default:
                begin
                    lng     = LONG_W'($urandom_range(0, 2500));
                    dbl     = DOUBLE_W'($urandom_range(0, 1500));
                    cnt     = COUNT_W'($urandom_range(1, 16));
                    max_gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
                end
            endcase
            write_reg(CFG_LONG_PRESS, {1'b0, lng});
            write_reg(CFG_DOUBLE_PRESS, dbl);
            write_reg(CFG_BUTTON_COUNT, {11'd0, cnt});
            cfg_wen <= 1'b0;
            settings_used++;

            used    = buttons_used();
            counted = 0;
            while (counted < PER_PHASE)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    // Noise: any index, level and timestamp.
                    b  = INDEX_W'($urandom_range(0, 15));
                    lv = 1'($urandom_range(0, 1));
                    t  = $urandom;
                end
                else
                begin
                    // Mostly stay on one button so that gestures build up.
                    if (b >= used || $urandom_range(0, 3) == 0)
                        b = INDEX_W'($urandom_range(0, used - 1));
                    lv   = ($urandom_range(0, 99) < 65) ? last_level[b] : !last_level[b];
                    base = action_stamp[b];
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: t = base + $urandom_range(0, 50);
                        4:          t = base + double_ms - $urandom_range(0, 1);
                        5:          t = base + long_ms + $urandom_range(0, 1);
                        6, 7:       t = base + $urandom_range(0, 3000);
                        8:          t = $urandom;
                        default:    t = base + $urandom_range(0, 2 * long_ms + 2);
                    endcase
                end
                last_level[b] = lv;
                if (b < used)
                    counted++;
                push_sample(b, lv, t, 1'b0, '0);
            end
        end

        settle_idle();
        repeat (10) @(posedge clk);

        $display("Sent %0d requests over %0d register settings; %0d results checked.",
                 samples_sent, settings_used, results_checked);
        $display("Results seen: rest %0d pressed %0d still %0d long %0d still-long %0d %s",
                 state_tally[0], state_tally[1], state_tally[2], state_tally[3],
                 state_tally[4], $sformatf("double %0d released %0d",
                                           state_tally[5], state_tally[6]));
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[button_gesture_classifier_top.f]
+incdir+hdl
hdl/bgc_pkg.sv
hdl/bgc_ctrl.sv
hdl/bgc_datapath.sv
hdl/button_gesture_classifier_top.sv
hdl/bgc_checker.sv
tb/sv/tb.sv
